/* rtl/cfc_pkg.sv */
// Chunk frustum cull: shared constants, matrix and pipeline data types.
// No dependencies; every module of the block imports this package.
package cfc_pkg;

  localparam int CHUNK_SIZE  = 32;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = 64;
  localparam int COEF_W      = 32;
  localparam int ORG_W       = 24;
  localparam int PROD_W      = COEF_W + ORG_W;
  localparam int ACC_W       = PROD_W + 4;
  localparam int PIPE_DEPTH  = 5;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ORG_W-1:0]  org_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic signed [ACC_W:0]    cmp_t;
  typedef logic [CFG_W-1:0]         cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  typedef enum logic [1:0] {
    ROW_X,
    ROW_Y,
    ROW_Z,
    ROW_W
  } row_t;

  typedef struct packed {
    coef_t cx;
    coef_t cy;
    coef_t cz;
    coef_t ct;
  } row_coef_t;

  typedef row_coef_t [NUM_ROWS-1:0] matrix_t;

  typedef struct packed {
    prod_t px;
    prod_t py;
    prod_t pz;
  } row_prod_t;

  typedef row_prod_t [NUM_ROWS-1:0]  prod_vec_t;
  typedef acc_t [NUM_ROWS-1:0]       clip_t;
  typedef clip_t [NUM_CORNERS-1:0]   corner_clip_t;

  typedef struct packed {
    logic valid;
  } stage_ctl_t;

endpackage

/* rtl/cfc_mul.sv */
// Chunk frustum cull: origin times matrix coefficients, twelve parallel products.
// Depends on cfc_pkg.
module cfc_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  cfc_pkg::stage_ctl_t ctl_in,
  input  cfc_pkg::org_t       org_x,
  input  cfc_pkg::org_t       org_y,
  input  cfc_pkg::org_t       org_z,
  input  cfc_pkg::matrix_t    matrix,
  output cfc_pkg::stage_ctl_t ctl_out,
  output cfc_pkg::prod_vec_t  prod
);
  import cfc_pkg::*;

  prod_vec_t  prod_nxt;
  prod_vec_t  prod_r;
  stage_ctl_t ctl_r;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      prod_nxt[r].px = prod_t'(matrix[r].cx) * prod_t'(org_x);
      prod_nxt[r].py = prod_t'(matrix[r].cy) * prod_t'(org_y);
      prod_nxt[r].pz = prod_t'(matrix[r].cz) * prod_t'(org_z);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign ctl_out = ctl_r;
  assign prod    = prod_r;

endmodule

/* rtl/cfc_sum.sv */
// Chunk frustum cull: clip value of the minimum corner, one sum per row.
// Depends on cfc_pkg.
module cfc_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  cfc_pkg::stage_ctl_t ctl_in,
  input  cfc_pkg::prod_vec_t  prod,
  input  cfc_pkg::matrix_t    matrix,
  output cfc_pkg::stage_ctl_t ctl_out,
  output cfc_pkg::clip_t      base
);
  import cfc_pkg::*;

  clip_t      base_nxt;
  clip_t      base_r;
  stage_ctl_t ctl_r;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      base_nxt[r] = acc_t'(prod[r].px) + acc_t'(prod[r].py) + acc_t'(prod[r].pz)
                  + acc_t'(matrix[r].ct);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
  end

  assign ctl_out = ctl_r;
  assign base    = base_r;

endmodule

/* rtl/cfc_corner.sv */
// Chunk frustum cull: clip values of all eight corners from the base corner.
// Depends on cfc_pkg.
module cfc_corner (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfc_pkg::stage_ctl_t   ctl_in,
  input  cfc_pkg::clip_t        base,
  input  cfc_pkg::matrix_t      matrix,
  output cfc_pkg::stage_ctl_t   ctl_out,
  output cfc_pkg::corner_clip_t clip
);
  import cfc_pkg::*;

  clip_t        off_x;
  clip_t        off_y;
  clip_t        off_z;
  corner_clip_t clip_nxt;
  corner_clip_t clip_r;
  stage_ctl_t   ctl_r;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      off_x[r] = acc_t'(matrix[r].cx) * acc_t'(CHUNK_SIZE);
      off_y[r] = acc_t'(matrix[r].cy) * acc_t'(CHUNK_SIZE);
      off_z[r] = acc_t'(matrix[r].cz) * acc_t'(CHUNK_SIZE);
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        clip_nxt[k][r] = base[r]
                       + (((k & 4) != 0) ? off_x[r] : acc_t'(0))
                       + (((k & 2) != 0) ? off_y[r] : acc_t'(0))
                       + (((k & 1) != 0) ? off_z[r] : acc_t'(0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    clip_r <= clip_nxt;
  end

  assign ctl_out = ctl_r;
  assign clip    = clip_r;

endmodule

/* rtl/cfc_test.sv */
// Chunk frustum cull: strict clip volume test per corner, OR into the result.
// Depends on cfc_pkg.
module cfc_test (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfc_pkg::stage_ctl_t   ctl_in,
  input  cfc_pkg::corner_clip_t clip,
  output logic                  res_valid,
  output logic                  res_visible
);
  import cfc_pkg::*;

  logic [NUM_CORNERS-1:0] corner_in;
  logic                   visible_nxt;
  logic                   visible_r;
  logic                   valid_r;

  function automatic logic is_pos(input cmp_t v);
    return !v[ACC_W] && (v != '0);
  endfunction

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      corner_in[k] = is_pos(cmp_t'(clip[k][ROW_W]) + cmp_t'(clip[k][ROW_X]))
                  && is_pos(cmp_t'(clip[k][ROW_W]) - cmp_t'(clip[k][ROW_X]))
                  && is_pos(cmp_t'(clip[k][ROW_W]) + cmp_t'(clip[k][ROW_Y]))
                  && is_pos(cmp_t'(clip[k][ROW_W]) - cmp_t'(clip[k][ROW_Y]))
                  && is_pos(cmp_t'(clip[k][ROW_Z]))
                  && is_pos(cmp_t'(clip[k][ROW_W]) - cmp_t'(clip[k][ROW_Z]));
    end
    visible_nxt = |corner_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    visible_r <= visible_nxt;
  end

  assign res_valid   = valid_r;
  assign res_visible = visible_r;

endmodule

/* rtl/chunk_frustum_cull.sv */
// Chunk frustum cull top level: matrix registers, input register, four pipeline stages.
// Depends on cfc_pkg, cfc_mul, cfc_sum, cfc_corner and cfc_test.
//
//   channel  ports                                   handshake
//   input    in_origin_x, in_origin_y, in_origin_z   start high, busy low
//   result   out_visible                             out_valid strobe, one cycle
//   config   cfg_index, cfg_data                     cfg_we, taken at once
//
// One item per cycle; the result strobe is registered through the input register,
// multiply, row sum, corner sum and compare stages, in that order.
// busy stays low: the pipeline never stalls and the receiver cannot stall it.
// Synchronous reset clears the matrix to zero and empties the pipeline.
module chunk_frustum_cull (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  cfc_pkg::org_t        in_origin_x,
  input  cfc_pkg::org_t        in_origin_y,
  input  cfc_pkg::org_t        in_origin_z,
  output logic                 out_valid,
  output logic                 out_visible,
  input  logic                 cfg_we,
  input  cfc_pkg::cfg_idx_t    cfg_index,
  input  cfc_pkg::cfg_word_t   cfg_data
);
  import cfc_pkg::*;

  cfg_word_t    cfg_r [NUM_REGS];
  matrix_t      matrix;
  org_t         org_x_r;
  org_t         org_y_r;
  org_t         org_z_r;
  stage_ctl_t   in_ctl_r;
  stage_ctl_t   in_ctl_nxt;
  stage_ctl_t   mul_ctl;
  stage_ctl_t   sum_ctl;
  stage_ctl_t   cor_ctl;
  prod_vec_t    prod;
  clip_t        base;
  corner_clip_t clip;

  assign busy             = 1'b0;
  assign in_ctl_nxt.valid = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[cfg_idx_t'(i)] <= '0;
      end
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      matrix[r].cx = coef_t'(cfg_r[cfg_idx_t'(2*r)][COEF_W-1:0]);
      matrix[r].cy = coef_t'(cfg_r[cfg_idx_t'(2*r)][CFG_W-1:COEF_W]);
      matrix[r].cz = coef_t'(cfg_r[cfg_idx_t'(2*r+1)][COEF_W-1:0]);
      matrix[r].ct = coef_t'(cfg_r[cfg_idx_t'(2*r+1)][CFG_W-1:COEF_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ctl_r <= '0;
    end else begin
      in_ctl_r <= in_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ctl_nxt.valid) begin
      org_x_r <= in_origin_x;
      org_y_r <= in_origin_y;
      org_z_r <= in_origin_z;
    end
  end

  cfc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (in_ctl_r),
    .org_x   (org_x_r),
    .org_y   (org_y_r),
    .org_z   (org_z_r),
    .matrix  (matrix),
    .ctl_out (mul_ctl),
    .prod    (prod)
  );

  cfc_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (mul_ctl),
    .prod    (prod),
    .matrix  (matrix),
    .ctl_out (sum_ctl),
    .base    (base)
  );

  cfc_corner u_corner (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_in  (sum_ctl),
    .base    (base),
    .matrix  (matrix),
    .ctl_out (cor_ctl),
    .clip    (clip)
  );

  cfc_test u_test (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_in      (cor_ctl),
    .clip        (clip),
    .res_valid   (out_valid),
    .res_visible (out_visible)
  );

endmodule

/* rtl/cfc_checker.sv */
// Chunk frustum cull: port-level checker for item timing, reset and configuration writes, bound to the top level.
// Depends on cfc_pkg and chunk_frustum_cull.
module cfc_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic cfg_we
);
  import cfc_pkg::*;

  logic accept;
  assign accept = start && !busy;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_DEPTH out_valid)
    else $error("accepted item produced no result");

  a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, PIPE_DEPTH))
    else $error("result without a matching item");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !accept)
    else $error("configuration write while an item enters");

endmodule

bind chunk_frustum_cull cfc_checker u_cfc_checker (.*);
